/* sv/pstt_pkg.sv */
// shared types, constants and helpers of the periodic timer table
`default_nettype none

package pstt_pkg;

  localparam int TIMER_SLOTS = 16;

  localparam int SLOT_W = $clog2(TIMER_SLOTS);
  localparam int PTR_W  = SLOT_W + 1;

  localparam int CMD_W        = 2;
  localparam int WIN_W        = 6;
  localparam int TID_W        = 16;
  localparam int IVL_W        = 16;
  localparam int KIND_W       = 3;
  localparam int SLOT_FIELD_W = 4;

  localparam logic [PTR_W-1:0]  NIL_PTR   = {PTR_W{1'b1}};
  localparam logic [PTR_W-1:0]  SLOTS_PTR = PTR_W'(TIMER_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TIMER_SLOTS - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_ADD     = 2'd1,
    CMD_REM_WIN = 2'd2,
    CMD_REM_ID  = 2'd3
  } pstt_cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_EXPIRY    = 3'd0,
    KIND_ADDED     = 3'd1,
    KIND_FULL      = 3'd2,
    KIND_REMOVED   = 3'd3,
    KIND_TICK_DONE = 3'd4
  } pstt_kind_e;

  typedef struct packed {
    logic [WIN_W-1:0] owner;
    logic [TID_W-1:0] tid;
    logic [IVL_W-1:0] period;
    logic [IVL_W-1:0] elapsed;
  } pstt_entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [PTR_W-1:0]  data;
  } pstt_link_wr_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    pstt_entry_t       data;
  } pstt_entry_wr_t;

  function automatic logic is_slot(input logic [PTR_W-1:0] p);
    return p < SLOTS_PTR;
  endfunction

  // low bits of a slot number as carried in a result
  function automatic logic [SLOT_FIELD_W-1:0] to_slot_field(input logic [PTR_W-1:0] p);
    logic [PTR_W+SLOT_FIELD_W-1:0] w;
    w = {{SLOT_FIELD_W{1'b0}}, p};
    return w[SLOT_FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* sv/pstt_if.sv */
// command and result channel interfaces of the periodic timer table
`default_nettype none

interface pstt_cmd_if;
  import pstt_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [WIN_W-1:0] window_id;
  logic [TID_W-1:0] timer_id;
  logic [IVL_W-1:0] interval;

  modport source (output valid, command, window_id, timer_id, interval, input ready);
  modport sink   (input valid, command, window_id, timer_id, interval, output ready);
endinterface

interface pstt_res_if;
  import pstt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic [WIN_W-1:0]        expired_window;
  logic [TID_W-1:0]        expired_timer;
  logic [SLOT_FIELD_W-1:0] slot;
  logic                    last;

  modport source (output valid, kind, expired_window, expired_timer, slot, last,
                  input ready);
  modport sink   (input valid, kind, expired_window, expired_timer, slot, last,
                  output ready);
endinterface

`default_nettype wire

/* sv/periodic_software_timer_table.sv */
// top level: list sequencer, list heads and result register of the timer table
`default_nettype none

// Table of TIMER_SLOTS periodic timers kept as an active list (newest first)
// and a free list in on-chip memories. After reset the free list is built
// by a sweep over all slots during which no command is taken. One command
// is handled at a time: a tick or a remove visits each active entry with a
// memory read, then an update using the shared entry unit, a remove adds
// a bridging step for each unlinked entry that has a predecessor, and every
// command has an acceptance step and a final result step. An add reads the
// free head, then links it in; a refused add goes straight to its result.
// Expiries and final results wait while the result side stalls.
module periodic_software_timer_table (
  input  wire            clk_i,
  input  wire            rst_ni,
  pstt_cmd_if.sink       in_i,
  pstt_res_if.source     out_o
);
  import pstt_pkg::*;

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_READ = 6'b000100,
    S_EVAL = 6'b001000,
    S_FIX  = 6'b010000,
    S_LAST = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] init_q, init_d;
  logic [PTR_W-1:0]  cur_q, cur_d;
  logic [PTR_W-1:0]  prev_q, prev_d;
  logic [PTR_W-1:0]  active_q, active_d;
  logic [PTR_W-1:0]  free_q, free_d;
  pstt_kind_e        fin_kind_q, fin_kind_d;
  logic [SLOT_FIELD_W-1:0] fin_slot_q, fin_slot_d;

  pstt_cmd_e         cmd_q;
  logic [WIN_W-1:0]  win_q;
  logic [TID_W-1:0]  tid_q;
  logic [IVL_W-1:0]  ivl_q;

  logic                    ov_q;
  pstt_kind_e              okind_q, okind_d;
  logic [WIN_W-1:0]        owin_q, owin_d;
  logic [TID_W-1:0]        otid_q, otid_d;
  logic [SLOT_FIELD_W-1:0] oslot_q, oslot_d;
  logic                    olast_q, olast_d;
  logic                    out_load;
  logic                    can_load;
  logic                    in_acc;

  pstt_link_wr_t    link_wr;
  pstt_entry_wr_t   ent_wr;
  logic [PTR_W-1:0] link_rd;
  pstt_entry_t      ent_rd;
  logic             hit;
  logic             expire;
  logic [IVL_W-1:0] count_nx;

  pstt_tables u_tables (
    .clk_i     (clk_i),
    .rd_en_i   (is_slot(cur_q)),
    .rd_addr_i (cur_q[SLOT_W-1:0]),
    .link_wr_i (link_wr),
    .ent_wr_i  (ent_wr),
    .link_rd_o (link_rd),
    .ent_rd_o  (ent_rd)
  );

  pstt_entry_unit u_entry (
    .ent_i    (ent_rd),
    .window_i (win_q),
    .timer_i  (tid_q),
    .by_id_i  (cmd_q == CMD_REM_ID),
    .hit_o    (hit),
    .expire_o (expire),
    .count_o  (count_nx)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && (state_q == S_IDLE);
  assign can_load   = !ov_q || out_o.ready;

  always_comb begin
    state_d    = state_q;
    init_d     = init_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    active_d   = active_q;
    free_d     = free_q;
    fin_kind_d = fin_kind_q;
    fin_slot_d = fin_slot_q;
    link_wr    = '0;
    ent_wr     = '0;
    out_load   = 1'b0;
    okind_d    = fin_kind_q;
    owin_d     = '0;
    otid_d     = '0;
    oslot_d    = fin_slot_q;
    olast_d    = 1'b1;

    unique case (state_q)
      S_INIT: begin
        link_wr.en   = 1'b1;
        link_wr.addr = init_q;
        link_wr.data = (init_q == LAST_SLOT) ? NIL_PTR : {1'b0, init_q} + PTR_W'(1);
        init_d       = init_q + SLOT_W'(1);
        if (init_q == LAST_SLOT) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          prev_d     = NIL_PTR;
          fin_slot_d = '0;
          unique case (pstt_cmd_e'(in_i.command))
            CMD_TICK: begin
              fin_kind_d = KIND_TICK_DONE;
              cur_d      = active_q;
              state_d    = is_slot(active_q) ? S_READ : S_LAST;
            end
            CMD_ADD: begin
              fin_kind_d = KIND_FULL;
              cur_d      = free_q;
              state_d    = is_slot(free_q) ? S_READ : S_LAST;
            end
            CMD_REM_WIN, CMD_REM_ID: begin
              fin_kind_d = KIND_REMOVED;
              cur_d      = active_q;
              state_d    = is_slot(active_q) ? S_READ : S_LAST;
            end
          endcase
        end
      end

      S_READ: begin
        state_d = S_EVAL;
      end

      S_EVAL: begin
        unique case (cmd_q)
          CMD_TICK: begin
            // an expiry waits here until the result register is free
            if (!expire || can_load) begin
              ent_wr.en           = 1'b1;
              ent_wr.addr         = cur_q[SLOT_W-1:0];
              ent_wr.data         = ent_rd;
              ent_wr.data.elapsed = count_nx;
              if (expire) begin
                out_load = 1'b1;
                okind_d  = KIND_EXPIRY;
                owin_d   = ent_rd.owner;
                otid_d   = ent_rd.tid;
                oslot_d  = to_slot_field(cur_q);
                olast_d  = 1'b0;
              end
              cur_d   = link_rd;
              state_d = is_slot(link_rd) ? S_READ : S_LAST;
            end
          end
          CMD_ADD: begin
            link_wr.en   = 1'b1;
            link_wr.addr = cur_q[SLOT_W-1:0];
            link_wr.data = active_q;
            ent_wr.en    = 1'b1;
            ent_wr.addr  = cur_q[SLOT_W-1:0];
            ent_wr.data  = '{owner: win_q, tid: tid_q, period: ivl_q, elapsed: '0};
            free_d       = link_rd;
            active_d     = cur_q;
            fin_kind_d   = KIND_ADDED;
            fin_slot_d   = to_slot_field(cur_q);
            state_d      = S_LAST;
          end
          CMD_REM_WIN, CMD_REM_ID: begin
            cur_d = link_rd;
            if (hit) begin
              link_wr.en   = 1'b1;
              link_wr.addr = cur_q[SLOT_W-1:0];
              link_wr.data = free_q;
              free_d       = cur_q;
              if (is_slot(prev_q)) begin
                state_d = S_FIX;
              end else begin
                active_d = link_rd;
                state_d  = is_slot(link_rd) ? S_READ : S_LAST;
              end
            end else begin
              prev_d  = cur_q;
              state_d = is_slot(link_rd) ? S_READ : S_LAST;
            end
          end
        endcase
      end

      S_FIX: begin
        // bridge the predecessor over the unlinked entry
        link_wr.en   = 1'b1;
        link_wr.addr = prev_q[SLOT_W-1:0];
        link_wr.data = cur_q;
        state_d      = is_slot(cur_q) ? S_READ : S_LAST;
      end

      S_LAST: begin
        if (can_load) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      init_q     <= '0;
      cur_q      <= NIL_PTR;
      prev_q     <= NIL_PTR;
      active_q   <= NIL_PTR;
      free_q     <= '0;
      fin_kind_q <= KIND_TICK_DONE;
      fin_slot_q <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      init_q     <= init_d;
      cur_q      <= cur_d;
      prev_q     <= prev_d;
      active_q   <= active_d;
      free_q     <= free_d;
      fin_kind_q <= fin_kind_d;
      fin_slot_q <= fin_slot_d;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // command fields held for the whole walk
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= pstt_cmd_e'(in_i.command);
      win_q <= in_i.window_id;
      tid_q <= in_i.timer_id;
      ivl_q <= in_i.interval;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      okind_q <= okind_d;
      owin_q  <= owin_d;
      otid_q  <= otid_d;
      oslot_q <= oslot_d;
      olast_q <= olast_d;
    end
  end

  assign out_o.valid          = ov_q;
  assign out_o.kind           = okind_q;
  assign out_o.expired_window = owin_q;
  assign out_o.expired_timer  = otid_q;
  assign out_o.slot           = oslot_q;
  assign out_o.last           = olast_q;

endmodule

`default_nettype wire

/* sv/pstt_tables.sv */
// link and entry memories, one write port each, shared registered read
`default_nettype none

module pstt_tables (
  input  wire                      clk_i,
  input  wire                      rd_en_i,
  input  wire [pstt_pkg::SLOT_W-1:0] rd_addr_i,
  input  wire pstt_pkg::pstt_link_wr_t  link_wr_i,
  input  wire pstt_pkg::pstt_entry_wr_t ent_wr_i,
  output logic [pstt_pkg::PTR_W-1:0] link_rd_o,
  output pstt_pkg::pstt_entry_t    ent_rd_o
);
  import pstt_pkg::*;

  logic [PTR_W-1:0] link_mem [TIMER_SLOTS];
  pstt_entry_t      ent_mem  [TIMER_SLOTS];

  logic [PTR_W-1:0] link_rd_q;
  pstt_entry_t      ent_rd_q;

  always_ff @(posedge clk_i) begin
    if (link_wr_i.en) begin
      link_mem[link_wr_i.addr] <= link_wr_i.data;
    end
    if (ent_wr_i.en) begin
      ent_mem[ent_wr_i.addr] <= ent_wr_i.data;
    end
    if (rd_en_i) begin
      link_rd_q <= link_mem[rd_addr_i];
      ent_rd_q  <= ent_mem[rd_addr_i];
    end
  end

  assign link_rd_o = link_rd_q;
  assign ent_rd_o  = ent_rd_q;

endmodule

`default_nettype wire

/* sv/pstt_entry_unit.sv */
// shared per-entry unit: match compare for removes, count step for ticks
`default_nettype none

module pstt_entry_unit (
  input  wire pstt_pkg::pstt_entry_t ent_i,
  input  wire [pstt_pkg::WIN_W-1:0]  window_i,
  input  wire [pstt_pkg::TID_W-1:0]  timer_i,
  input  wire                        by_id_i,
  output logic                       hit_o,
  output logic                       expire_o,
  output logic [pstt_pkg::IVL_W-1:0] count_o
);
  import pstt_pkg::*;

  logic [IVL_W-1:0] inc;

  always_comb begin
    hit_o    = (ent_i.owner == window_i) && (!by_id_i || (ent_i.tid == timer_i));
    inc      = ent_i.elapsed + IVL_W'(1);
    // wrap to zero counts as an expiry too
    expire_o = (inc >= ent_i.period) || (inc == '0);
    count_o  = expire_o ? '0 : inc;
  end

endmodule

`default_nettype wire

/* verif/periodic_software_timer_table_tb.sv */
// self-checking testbench of the timer table: predicts and checks results in order
module periodic_software_timer_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pstt_pkg::*;

  typedef struct packed {
    pstt_cmd_e        cmd;
    logic [WIN_W-1:0] win;
    logic [TID_W-1:0] tid;
    logic [IVL_W-1:0] ivl;
  } timer_cmd_t;

  typedef struct packed {
    pstt_kind_e              kind;
    logic [WIN_W-1:0]        win;
    logic [TID_W-1:0]        tid;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    last;
  } timer_res_t;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_SPARSE,
    RX_COIN,
    RX_PERIODIC
  } rx_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pstt_cmd_if cmd_if ();
  pstt_res_if res_if ();

  periodic_software_timer_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if.sink),
    .out_o  (res_if.source)
  );

  always #5 clk_i = ~clk_i;

  timer_cmd_t commands_to_send[$];
  timer_res_t results_due[$];
  int         errors = 0;

  // shadow of the timer table
  logic [PTR_W-1:0] link_of[TIMER_SLOTS];
  logic [PTR_W-1:0] busy_head;
  logic [PTR_W-1:0] spare_head;
  logic [WIN_W-1:0] win_of[TIMER_SLOTS];
  logic [TID_W-1:0] tid_of[TIMER_SLOTS];
  logic [IVL_W-1:0] period_of[TIMER_SLOTS];
  logic [IVL_W-1:0] count_of[TIMER_SLOTS];

  function automatic void owe_result(pstt_kind_e kind, logic [WIN_W-1:0] win,
                                     logic [TID_W-1:0] tid, logic [PTR_W-1:0] slot,
                                     logic last);
    timer_res_t r;
    r.kind = kind;
    r.win  = win;
    r.tid  = tid;
    r.slot = slot[SLOT_FIELD_W-1:0];
    r.last = last;
    results_due.push_back(r);
  endfunction

  task automatic step_timer_table(input pstt_cmd_e cmd, input logic [WIN_W-1:0] win,
                                  input logic [TID_W-1:0] tid,
                                  input logic [IVL_W-1:0] ivl);
    logic [PTR_W-1:0]  p;
    logic [PTR_W-1:0]  prev;
    logic [PTR_W-1:0]  nxt;
    logic [SLOT_W-1:0] s;
    logic [IVL_W-1:0]  cnt;
    int                g;
    case (cmd)
      CMD_TICK: begin
        p = busy_head;
        for (g = 0; g < TIMER_SLOTS && p < TIMER_SLOTS; g++) begin
          s   = p[SLOT_W-1:0];
          cnt = count_of[s] + 1'b1;
          // a count that wraps to zero also fires
          if (cnt >= period_of[s] || cnt == '0) begin
            cnt = '0;
            owe_result(KIND_EXPIRY, win_of[s], tid_of[s], p, 1'b0);
          end
          count_of[s] = cnt;
          p = link_of[s];
        end
        owe_result(KIND_TICK_DONE, '0, '0, '0, 1'b1);
      end
      CMD_ADD: begin
        p = spare_head;
        if (p >= TIMER_SLOTS) begin
          owe_result(KIND_FULL, '0, '0, '0, 1'b1);
        end else begin
          s            = p[SLOT_W-1:0];
          spare_head   = link_of[s];
          link_of[s]   = busy_head;
          busy_head    = p;
          win_of[s]    = win;
          tid_of[s]    = tid;
          period_of[s] = ivl;
          count_of[s]  = '0;
          owe_result(KIND_ADDED, '0, '0, p, 1'b1);
        end
      end
      default: begin
        prev = NIL_PTR;
        p    = busy_head;
        for (g = 0; g < TIMER_SLOTS && p < TIMER_SLOTS; g++) begin
          s   = p[SLOT_W-1:0];
          nxt = link_of[s];
          if (win_of[s] == win && (cmd == CMD_REM_WIN || tid_of[s] == tid)) begin
            if (prev < TIMER_SLOTS) link_of[prev[SLOT_W-1:0]] = nxt;
            else busy_head = nxt;
            link_of[s] = spare_head;
            spare_head = p;
          end else begin
            prev = p;
          end
          p = nxt;
        end
        owe_result(KIND_REMOVED, '0, '0, '0, 1'b1);
      end
    endcase
  endtask

  function automatic void queue_cmd(pstt_cmd_e cmd, int unsigned win, int unsigned tid,
                                    int unsigned ivl);
    timer_cmd_t c;
    c.cmd = cmd;
    c.win = win[WIN_W-1:0];
    c.tid = tid[TID_W-1:0];
    c.ivl = ivl[IVL_W-1:0];
    commands_to_send.push_back(c);
  endfunction

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // command sender: bursts of transfers separated by random gaps
  timer_cmd_t next_cmd;
  int         burst_left;
  int         gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid     <= 1'b0;
      cmd_if.command   <= '0;
      cmd_if.window_id <= '0;
      cmd_if.timer_id  <= '0;
      cmd_if.interval  <= '0;
      burst_left       <= 1;
      gap_left         <= 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        step_timer_table(pstt_cmd_e'(cmd_if.command), cmd_if.window_id, cmd_if.timer_id,
                         cmd_if.interval);
      end
      if (cmd_if.valid && !cmd_if.ready) begin
        // hold the offered command until it transfers
      end else if (gap_left > 0) begin
        gap_left     <= gap_left - 1;
        cmd_if.valid <= 1'b0;
      end else if (commands_to_send.size() > 0) begin
        next_cmd          = commands_to_send.pop_front();
        cmd_if.valid     <= 1'b1;
        cmd_if.command   <= next_cmd.cmd;
        cmd_if.window_id <= next_cmd.win;
        cmd_if.timer_id  <= next_cmd.tid;
        cmd_if.interval  <= next_cmd.ivl;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // result receiver: ready follows a randomly chosen mode, redrawn when its run ends
  timer_res_t want_res;
  rx_mode_e   rx_mode;
  int         rx_mode_left;
  int         rx_phase;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      rx_mode      <= RX_STEADY;
      rx_mode_left <= 0;
      rx_phase     <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none actual kind %0d slot %0d last %0d",
                   $time, res_if.kind, res_if.slot, res_if.last);
          errors++;
        end else begin
          want_res = results_due.pop_front();
          check_field("kind", want_res.kind, res_if.kind);
          check_field("expired_window", want_res.win, res_if.expired_window);
          check_field("expired_timer", want_res.tid, res_if.expired_timer);
          check_field("slot", want_res.slot, res_if.slot);
          check_field("last", want_res.last, res_if.last);
        end
      end
      rx_phase <= rx_phase + 1;
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_e'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(16, 80);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_STEADY:   res_if.ready <= 1'b1;
        RX_SPARSE:   res_if.ready <= ($urandom_range(0, 3) == 0);
        RX_COIN:     res_if.ready <= $urandom_range(0, 1);
        RX_PERIODIC: res_if.ready <= (rx_phase % 5 != 0);
        default:     res_if.ready <= 1'b1;
      endcase
    end
  end

  initial begin
    int          i;
    int          r;
    int unsigned w;
    int unsigned t;
    int unsigned v;
    cmd_if.valid     = 1'b0;
    cmd_if.command   = '0;
    cmd_if.window_id = '0;
    cmd_if.timer_id  = '0;
    cmd_if.interval  = '0;
    res_if.ready     = 1'b0;

    for (i = 0; i < TIMER_SLOTS; i++) begin
      link_of[SLOT_W'(i)]   = PTR_W'(i + 1);
      win_of[SLOT_W'(i)]    = '0;
      tid_of[SLOT_W'(i)]    = '0;
      period_of[SLOT_W'(i)] = '0;
      count_of[SLOT_W'(i)]  = '0;
    end
    link_of[LAST_SLOT] = NIL_PTR;
    busy_head          = NIL_PTR;
    spare_head         = '0;

    // empty table: tick and removes find nothing
    queue_cmd(CMD_TICK, 0, 0, 0);
    queue_cmd(CMD_REM_WIN, 0, 0, 0);
    queue_cmd(CMD_REM_ID, 63, 16'hFFFF, 0);
    // fill every slot, field extremes first
    queue_cmd(CMD_ADD, 0, 0, 0);
    queue_cmd(CMD_ADD, 63, 16'hFFFF, 16'hFFFF);
    queue_cmd(CMD_ADD, 63, 16'hFFFF, 1);
    queue_cmd(CMD_ADD, 0, 16'h5555, 2);
    for (i = 4; i < TIMER_SLOTS; i++) queue_cmd(CMD_ADD, i, 16'hAAAA ^ i, i % 4);
    queue_cmd(CMD_ADD, 42, 16'h1234, 3);          // table full
    queue_cmd(CMD_TICK, 0, 0, 0);
    queue_cmd(CMD_TICK, 0, 0, 0);
    queue_cmd(CMD_REM_ID, 63, 16'hFFFF, 0);
    queue_cmd(CMD_REM_WIN, 0, 0, 0);
    queue_cmd(CMD_TICK, 0, 0, 0);
    queue_cmd(CMD_ADD, 7, 16'h0F0F, 5);

    // ids and windows mostly from a small pool so removes hit
    for (i = 0; i < 320; i++) begin
      r = $urandom_range(0, 99);
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 3);
      t = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 65535) : $urandom_range(0, 3);
      case ($urandom_range(0, 9))
        0, 1:    v = $urandom_range(0, 65535);
        2:       v = ($urandom_range(0, 1) == 0) ? 0 : 16'hFFFF;
        default: v = $urandom_range(0, 6);
      endcase
      if (r < 40)      queue_cmd(CMD_ADD, w, t, v);
      else if (r < 75) queue_cmd(CMD_TICK, w, t, v);
      else if (r < 88) queue_cmd(CMD_REM_WIN, w, t, v);
      else             queue_cmd(CMD_REM_ID, w, t, v);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (commands_to_send.size() != 0 || cmd_if.valid || results_due.size() != 0);
    repeat (40) @(posedge clk_i);

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, results_due.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* files.f */
sv/pstt_pkg.sv
sv/pstt_if.sv
sv/pstt_tables.sv
sv/pstt_entry_unit.sv
sv/periodic_software_timer_table.sv
verif/periodic_software_timer_table_tb.sv
